[rtl/core/spq_pkg.sv]
// spq_pkg: shared types and constants for the stable priority queue.
// Used by spq_cell, stable_priority_queue and spq_checker.
// No dependencies.
package spq_pkg;

	// Width of the running enqueue counters
	localparam int CNT_W = 32;

	// Result status codes
	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} spq_status_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;   // insert the new item, shifting lower entries down
		logic deq;   // remove the head, shifting all entries up
	} spq_cmd_t;

endpackage

[rtl/core/spq_cell.sv]
// spq_cell: one slot of the sorted shift-register chain.
// Holds a priority and payload and trades them with its neighbours.
// Depends on spq_pkg.
module spq_cell #(
	parameter int PRIORITY_BITS = 4,
	parameter int PAYLOAD_BITS  = 32
) (
	input  logic                     clk,
	input  spq_pkg::spq_cmd_t        cmd,
	input  logic                     occ,        // slot holds a live entry
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]  new_pay,
	input  logic                     left_keep,  // upper neighbour keeps its entry
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [PAYLOAD_BITS-1:0]  left_pay,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	input  logic [PAYLOAD_BITS-1:0]  right_pay,
	output logic                     keep,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [PAYLOAD_BITS-1:0]  pay
);

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;

	// Live entry of equal or higher priority stays put on an insert
	assign keep = occ && (prio_q >= new_prio);

	// Slot update: hold, take the new item, or shift from a neighbour
	always_ff @(posedge clk) begin
		if (cmd.enq && !keep) begin
			if (left_keep) begin
				prio_q <= new_prio;
				pay_q  <= new_pay;
			end else begin
				prio_q <= left_prio;
				pay_q  <= left_pay;
			end
		end else if (cmd.deq) begin
			prio_q <= right_prio;
			pay_q  <= right_pay;
		end
	end

	assign prio = prio_q;
	assign pay  = pay_q;

endmodule

[rtl/core/stable_priority_queue.sv]
// Stable priority queue: sorted shift-register chain with FIFO order per priority.
// The result strobes on done in the cycle after the item is taken.
// Throughput: one item per cycle; busy stays low, as every cell updates on the same clock edge.
// The receiver cannot stall; done is high for exactly one cycle per item.
// Reset clears the fill count, both counters and done; slot contents are not cleared.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 4,
	parameter int PAYLOAD_BITS  = 32,
	localparam int OCC_W        = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic [PRIORITY_BITS-1:0] priority_req,
	input  logic [PAYLOAD_BITS-1:0]  payload,
	output logic                     done,
	output logic [1:0]               status,
	output logic [PRIORITY_BITS-1:0] out_priority,
	output logic [PAYLOAD_BITS-1:0]  out_payload,
	output logic [OCC_W-1:0]         occupancy,
	output logic [spq_pkg::CNT_W-1:0] total_accepted,
	output logic [spq_pkg::CNT_W-1:0] high_accepted
);

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     do_enq;
	logic                     do_deq;
	spq_pkg::spq_cmd_t        cmd;

	logic [OCC_W-1:0]         count_q;
	logic [spq_pkg::CNT_W-1:0] total_q;
	logic [spq_pkg::CNT_W-1:0] high_q;
	logic                     done_q;
	spq_pkg::spq_status_t     status_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic [PAYLOAD_BITS-1:0]  out_pay_q;

	logic                     keep_w [CAPACITY+1];
	logic [PRIORITY_BITS-1:0] prio_w [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  pay_w  [CAPACITY];

	// Handshake and command decode
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == OCC_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign do_enq = accept && !action && !full;
	assign do_deq = accept && action && !empty;
	assign cmd.enq = do_enq;
	assign cmd.deq = do_deq;

	// Chain of slots; slot 0 is the head
	assign keep_w[0] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     occ;
		logic [PRIORITY_BITS-1:0] left_prio;
		logic [PAYLOAD_BITS-1:0]  left_pay;
		logic [PRIORITY_BITS-1:0] right_prio;
		logic [PAYLOAD_BITS-1:0]  right_pay;

		assign occ = (count_q > OCC_W'(i));

		if (i == 0) begin : g_head
			assign left_prio = priority_req;
			assign left_pay  = payload;
		end else begin : g_mid
			assign left_prio = prio_w[i-1];
			assign left_pay  = pay_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_prio = '0;
			assign right_pay  = '0;
		end else begin : g_body
			assign right_prio = prio_w[i+1];
			assign right_pay  = pay_w[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (occ),
			.new_prio  (priority_req),
			.new_pay   (payload),
			.left_keep (keep_w[i]),
			.left_prio (left_prio),
			.left_pay  (left_pay),
			.right_prio(right_prio),
			.right_pay (right_pay),
			.keep      (keep_w[i+1]),
			.prio      (prio_w[i]),
			.pay       (pay_w[i])
		);
	end

	// Fill count, enqueue counters and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			high_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (do_enq) begin
				count_q <= count_q + OCC_W'(1);
				total_q <= total_q + spq_pkg::CNT_W'(1);
				if (priority_req == PRIORITY_BITS'(1)) begin
					high_q <= high_q + spq_pkg::CNT_W'(1);
				end
			end else if (do_deq) begin
				count_q <= count_q - OCC_W'(1);
			end
		end
	end

	// Result register: status and head entry on a dequeue
	always_ff @(posedge clk) begin
		if (accept) begin
			out_prio_q <= '0;
			out_pay_q  <= '0;
			if (!action) begin
				status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
			end else if (empty) begin
				status_q <= spq_pkg::ST_EMPTY;
			end else begin
				status_q   <= spq_pkg::ST_DEQ;
				out_prio_q <= prio_w[0];
				out_pay_q  <= pay_w[0];
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_priority   = out_prio_q;
	assign out_payload    = out_pay_q;
	assign occupancy      = count_q;
	assign total_accepted = total_q;
	assign high_accepted  = high_q;

endmodule

[rtl/core/spq_checker.sv]
// spq_checker: port-level assertions for the stable priority queue.
// Bound to stable_priority_queue below; depends on spq_pkg.
module spq_checker #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 4,
	parameter int PAYLOAD_BITS  = 32,
	localparam int OCC_W        = $clog2(CAPACITY + 1)
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [1:0]                status,
	input logic [PRIORITY_BITS-1:0]  out_priority,
	input logic [PAYLOAD_BITS-1:0]   out_payload,
	input logic [OCC_W-1:0]          occupancy,
	input logic [spq_pkg::CNT_W-1:0] total_accepted
);

	// Every accepted item gives exactly one result in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted item");

	// Empty dequeue leaves nothing held and returns zeros
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_EMPTY) |->
			(occupancy == '0 && out_priority == '0 && out_payload == '0))
		else $error("empty dequeue with entries held or non-zero data");

	// A dropped enqueue only happens at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
		else $error("drop reported below capacity");

	// The accepted counter moves only with a successful enqueue
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != spq_pkg::ST_ENQ) |-> (total_accepted == $past(total_accepted)))
		else $error("accepted counter moved without an enqueue");

endmodule

bind stable_priority_queue spq_checker #(
	.CAPACITY     (CAPACITY),
	.PRIORITY_BITS(PRIORITY_BITS),
	.PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.out_priority  (out_priority),
	.out_payload   (out_payload),
	.occupancy     (occupancy),
	.total_accepted(total_accepted)
);
